/* hw/rtl/tlik_pkg.sv */
// shared types, constants and helper functions of the arm inverse kinematics block
package tlik_pkg;

	localparam int COORD_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// magnitude width entering the angle units, rotator width, binary angle width
	localparam int MAG_W = 48;
	localparam int XY_W  = 44;
	localparam int Z_W   = 36;
	// radicand and root width of the square root chain
	localparam int SQ_W  = 62;
	localparam int SQRT_CELLS = 31;
	// normalized magnitude lands in [2^NORM_LO, 2^(NORM_LO+1))
	localparam int NORM_LO    = 40;
	localparam int NORM_CELLS = 9;
	// bits of the turn count left after scaling by the centidegree turn
	localparam int Q_W = Z_W + 16 - 32;

	localparam logic [15:0] CENTI_TURN = 16'd36000;
	localparam logic [15:0] CENTI_HALF = 16'd18000;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE  = 2'd0,
		CFG_LINK1 = 2'd1,
		CFG_LINK2 = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [MAG_W-1:0] mx;
		logic [MAG_W-1:0] my;
		logic             xn;
		logic             yn;
		logic             zero;
	} norm_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} rot_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	function automatic logic [31:0] atan_tab(input int i);
		logic [31:0] t;
		case (i)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			24: t = 32'h00000029;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000003;
			29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

	// right shifts 4, 2, 1 bring the top below 2^41, left shifts 32..1 lift it to 2^40
	function automatic int norm_shift(input int j);
		int s;
		case (j)
			0: s = 4;
			1: s = 2;
			2: s = 1;
			3: s = 32;
			4: s = 16;
			5: s = 8;
			6: s = 4;
			7: s = 2;
			default: s = 1;
		endcase
		return s;
	endfunction

	function automatic bit norm_left(input int j);
		return j >= 3;
	endfunction

	function automatic norm_t vec_mag(input logic signed [MAG_W-1:0] yv,
		input logic signed [MAG_W-1:0] xv);
		norm_t n;
		n.xn   = xv[MAG_W-1];
		n.yn   = yv[MAG_W-1];
		n.mx   = n.xn ? -xv : xv;
		n.my   = n.yn ? -yv : yv;
		n.zero = (xv == '0) && (yv == '0);
		return n;
	endfunction

	// left half plane folds over with a start angle of +pi or -pi
	// an x shifted down to zero stays in the right half plane
	function automatic rot_t rot_init(input norm_t n);
		rot_t r;
		logic signed [XY_W-1:0] ym;
		logic signed [Z_W-1:0]  pi_a;
		logic                   fold;
		pi_a   = Z_W'(64'd2147483648);
		fold   = n.xn && (n.mx != '0);
		ym     = XY_W'(n.my);
		r.x    = XY_W'(n.mx);
		r.y    = (fold ^ n.yn) ? -ym : ym;
		r.z    = '0;
		if (fold) begin
			r.z = (n.yn && (n.my != '0)) ? -pi_a : pi_a;
		end
		r.zero = n.zero;
		return r;
	endfunction

endpackage

/* hw/rtl/tlik_delay.sv */
// enabled shift line that carries side data alongside the datapath cells
module tlik_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < D; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[D-1];

endmodule

/* hw/rtl/tlik_sqrt_cell.sv */
// one root bit of the pipelined integer square root
module tlik_sqrt_cell #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            en,
	input  tlik_pkg::sqrt_t din,
	output tlik_pkg::sqrt_t dout
);
	import tlik_pkg::*;

	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

	logic [SQ_W:0] trial;
	sqrt_t nxt;

	always_comb begin
		trial = {1'b0, din.root} + {1'b0, BIT};
		nxt   = din;
		if ({1'b0, din.rem} >= trial) begin
			nxt.rem  = din.rem - trial[SQ_W-1:0];
			nxt.root = (din.root >> 1) + BIT;
		end else begin
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

/* hw/rtl/tlik_norm_cell.sv */
// one conditional shift of the operand normalizer ahead of a cordic
module tlik_norm_cell #(
	parameter int SHIFT = 1,
	parameter bit LEFT  = 1'b0
) (
	input  logic            clk,
	input  logic            en,
	input  tlik_pkg::norm_t din,
	output tlik_pkg::norm_t dout
);
	import tlik_pkg::*;

	localparam int POS = LEFT ? NORM_LO + 1 - SHIFT : NORM_LO + SHIFT;
	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << POS;

	logic [MAG_W-1:0] mmax;
	logic take;
	norm_t nxt;

	always_comb begin
		mmax = (din.mx > din.my) ? din.mx : din.my;
		take = LEFT ? (mmax < LIM) : (mmax >= LIM);
		nxt  = din;
		if (take) begin
			nxt.mx = LEFT ? (din.mx << SHIFT) : (din.mx >> SHIFT);
			nxt.my = LEFT ? (din.my << SHIFT) : (din.my >> SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

/* hw/rtl/tlik_cordic_cell.sv */
// one vectoring micro-rotation of a cordic
module tlik_cordic_cell #(
	parameter int I = 0
) (
	input  logic           clk,
	input  logic           en,
	input  tlik_pkg::rot_t din,
	output tlik_pkg::rot_t dout
);
	import tlik_pkg::*;

	localparam logic signed [Z_W-1:0] STEP = $signed(Z_W'(atan_tab(I)));

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	rot_t nxt;

	always_comb begin
		xs  = din.x >>> I;
		ys  = din.y >>> I;
		nxt = din;
		if (!din.y[XY_W-1]) begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + STEP;
		end else begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - STEP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

/* hw/rtl/two_link_arm_inverse_kinematics.sv */
// top level: two-link planar arm inverse kinematics pipeline
// Takes one target point and the present joint angles per cycle, unless stalled, and returns
// goal angles in centidegrees (0..35999), spin directions and an out-of-reach flag. The
// datapath is fully pipelined: a new item is taken every cycle unless the input stalls. Its
// depth is set by the 31-cell square root chain and the three parallel cordic chains of
// CORDIC_STEPS cells, each behind a 9-cell operand normalizer.
// A two-entry output buffer lets the pipeline keep moving while one result waits; the input
// stalls only while both entries are held. Link lengths and mode may be written only while
// no item is in flight; the block needs no clearing pass after reset.
module two_link_arm_inverse_kinematics #(
	parameter int COORD_WIDTH  = tlik_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tlik_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlik_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// target_x, target_y, current_angle_1, current_angle_2, zero fill
	input  logic [((2*COORD_WIDTH+32+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// goal_angle_1, goal_angle_2, spin_dir_1, spin_dir_2, zero fill
	output logic [39:0]                       m_tdata,
	// out_of_reach
	output logic                              m_tuser
);
	import tlik_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int SQW = 2 * CW + 1;
	localparam int EW  = (SQW > 32 ? SQW : 32) + 1;
	localparam int LAT = 50 + CORDIC_STEPS;

	typedef struct packed {
		logic [15:0] g1;
		logic [15:0] g2;
		logic        d1;
		logic        d2;
		logic        oor;
	} out_t;

	// configuration
	logic        mode_q;
	logic [14:0] link1_q;
	logic [14:0] link2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			link1_q <= 15'd1000;
			link2_q <= 15'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[0];
				CFG_LINK1: link1_q <= cfg_data;
				CFG_LINK2: link2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	logic en;
	logic [LAT-1:0] vld_q;
	logic hv_q, sv_q;

	assign en       = !(hv_q && sv_q) || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: squares
	logic signed [CW-1:0]   x_in, y_in;
	logic signed [2*CW-1:0] xx_c, yy_c;
	logic [29:0] l11_c, l22_c, l12_c;
	logic signed [CW-1:0] x_s1, y_s1;
	logic [2*CW-1:0] xx_s1, yy_s1;
	logic [29:0] l11_s1, l22_s1, l12_s1;

	assign x_in  = s_tdata[CW-1:0];
	assign y_in  = s_tdata[2*CW-1:CW];
	assign xx_c  = x_in * x_in;
	assign yy_c  = y_in * y_in;
	assign l11_c = link1_q * link1_q;
	assign l22_c = link2_q * link2_q;
	assign l12_c = link1_q * link2_q;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			xx_s1  <= xx_c;
			yy_s1  <= yy_c;
			l11_s1 <= l11_c;
			l22_s1 <= l22_c;
			l12_s1 <= l12_c;
		end
	end

	// stage 2: elbow cosine numerator, reach test
	logic [EW-1:0] sq_e, lsum_e, n_e, d_e;
	logic oor_c;
	logic signed [32:0] d_c;
	logic [32:0] ad_w;
	logic [30:0] n_s2, ad_s2;
	logic signed [32:0] d_s2;

	always_comb begin
		sq_e   = EW'(xx_s1) + EW'(yy_s1);
		lsum_e = EW'(l11_s1) + EW'(l22_s1);
		n_e    = EW'({l12_s1, 1'b0});
		oor_c  = (sq_e > lsum_e + n_e) || (sq_e + n_e < lsum_e);
		d_e    = sq_e - lsum_e;
		d_c    = d_e[32:0];
		ad_w   = d_c[32] ? -d_c : d_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2  <= n_e[30:0];
			d_s2  <= d_c;
			ad_s2 <= ad_w[30:0];
		end
	end

	// stages 3 and 4: radicand n*n - d*d
	logic [SQ_W-1:0] nn_s3, dd_s3, r_s4;
	logic [30:0] n_s3, n_s4;
	logic signed [32:0] d_s3, d_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nn_s3 <= n_s2 * n_s2;
			dd_s3 <= ad_s2 * ad_s2;
			n_s3  <= n_s2;
			d_s3  <= d_s2;
			r_s4  <= nn_s3 - dd_s3;
			n_s4  <= n_s3;
			d_s4  <= d_s3;
		end
	end

	// square root chain
	sqrt_t sq_chain [SQRT_CELLS+1];
	assign sq_chain[0] = '{rem: r_s4, root: '0};

	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		tlik_sqrt_cell #(.K(SQRT_CELLS - 1 - k)) u_sqrt (
			.clk  (clk),
			.en   (en),
			.din  (sq_chain[k]),
			.dout (sq_chain[k+1])
		);
	end

	// side data riding along the chains
	logic [30:0] n_dly;
	logic signed [32:0] d_dly;
	logic signed [CW-1:0] x_dly, y_dly;
	logic [15:0] cur1_dly, cur2_dly;
	logic oor_dly;

	tlik_delay #(.W(64), .D(SQRT_CELLS)) u_nd_dly (
		.clk (clk), .en (en), .din ({n_s4, d_s4}), .dout ({n_dly, d_dly})
	);
	tlik_delay #(.W(2 * CW), .D(SQRT_CELLS + 4)) u_xy_dly (
		.clk (clk), .en (en), .din ({x_s1, y_s1}), .dout ({x_dly, y_dly})
	);
	tlik_delay #(.W(32), .D(LAT)) u_cur_dly (
		.clk  (clk),
		.en   (en),
		.din  (s_tdata[2*CW+31:2*CW]),
		.dout ({cur2_dly, cur1_dly})
	);
	tlik_delay #(.W(1), .D(LAT - 1)) u_oor_dly (
		.clk (clk), .en (en), .din (oor_c), .dout (oor_dly)
	);

	// stage 5: elbow term products
	logic [30:0] s_c, s_s5;
	logic signed [32:0] d_s5;
	logic [45:0] p_l2s_c, p_l1n_c, p_l2s_s5, p_l1n_s5;
	logic signed [MAG_W-1:0] p_l2d_c, p_l2d_s5;

	assign s_c     = sq_chain[SQRT_CELLS].root[30:0];
	assign p_l2s_c = link2_q * s_c;
	assign p_l1n_c = link1_q * n_dly;
	assign p_l2d_c = $signed({1'b0, link2_q}) * d_dly;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5     <= s_c;
			d_s5     <= d_dly;
			p_l2s_s5 <= p_l2s_c;
			p_l1n_s5 <= p_l1n_c;
			p_l2d_s5 <= p_l2d_c;
		end
	end

	// stage 6: operands of the three angle units
	// unit 0 is the base angle, unit 1 the elbow angle, unit 2 the elbow correction
	norm_t nrm [3][NORM_CELLS+1];
	logic signed [MAG_W-1:0] xe, ye, c_xv;

	assign xe   = MAG_W'(x_dly);
	assign ye   = MAG_W'(y_dly);
	assign c_xv = $signed(MAG_W'(p_l1n_s5)) + p_l2d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			nrm[0][0] <= mode_q ? vec_mag(ye, xe) : vec_mag(xe, ye);
			nrm[1][0] <= vec_mag($signed(MAG_W'(s_s5)), MAG_W'(d_s5));
			nrm[2][0] <= vec_mag($signed(MAG_W'(p_l2s_s5)), c_xv);
		end
	end

	rot_t rot [3][CORDIC_STEPS+1];

	for (genvar u = 0; u < 3; u++) begin : g_unit
		for (genvar j = 0; j < NORM_CELLS; j++) begin : g_norm
			tlik_norm_cell #(.SHIFT(norm_shift(j)), .LEFT(norm_left(j))) u_norm (
				.clk  (clk),
				.en   (en),
				.din  (nrm[u][j]),
				.dout (nrm[u][j+1])
			);
		end

		// stage 7: fold into the right half plane
		always_ff @(posedge clk) begin
			if (en) begin
				rot[u][0] <= rot_init(nrm[u][NORM_CELLS]);
			end
		end

		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
			tlik_cordic_cell #(.I(i)) u_rot (
				.clk  (clk),
				.en   (en),
				.din  (rot[u][i]),
				.dout (rot[u][i+1])
			);
		end
	end

	// stage 8: joint angles in binary angle units
	localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(64'd1073741824);
	localparam logic signed [Z_W-1:0] TURN    = Z_W'(64'd4294967296);

	logic signed [Z_W-1:0] a_z, t2_z, phi_z, za1_s8, za2_s8;

	always_comb begin
		a_z   = rot[0][CORDIC_STEPS].zero ? '0 : rot[0][CORDIC_STEPS].z;
		t2_z  = rot[1][CORDIC_STEPS].zero ? '0 : rot[1][CORDIC_STEPS].z;
		phi_z = rot[2][CORDIC_STEPS].zero ? '0 : rot[2][CORDIC_STEPS].z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			za1_s8 <= mode_q ? (HALF_PI - a_z + phi_z) : a_z;
			za2_s8 <= TURN - t2_z;
		end
	end

	// stage 9: scale magnitudes to centidegrees
	logic [Z_W-1:0] m1_c, m2_c;
	logic [Z_W+15:0] prod1_s9, prod2_s9;
	logic neg1_s9, neg2_s9;

	assign m1_c = za1_s8[Z_W-1] ? -za1_s8 : za1_s8;
	assign m2_c = za2_s8[Z_W-1] ? -za2_s8 : za2_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			prod1_s9 <= m1_c * CENTI_TURN;
			prod2_s9 <= m2_c * CENTI_TURN;
			neg1_s9  <= za1_s8[Z_W-1];
			neg2_s9  <= za2_s8[Z_W-1];
		end
	end

	// stage 10: wrap into one turn
	function automatic logic [15:0] centi_wrap(input logic [Q_W-1:0] q, input logic neg);
		logic [Q_W-1:0] r;
		r = q;
		if (r >= Q_W'(144000)) r = r - Q_W'(144000);
		if (r >= Q_W'(72000))  r = r - Q_W'(72000);
		if (r >= Q_W'(36000))  r = r - Q_W'(36000);
		return (neg && (r != '0)) ? CENTI_TURN - 16'(r) : 16'(r);
	endfunction

	logic [15:0] c1_s10, c2_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s10 <= centi_wrap(prod1_s9[Z_W+15:32], neg1_s9);
			c2_s10 <= centi_wrap(prod2_s9[Z_W+15:32], neg2_s9);
		end
	end

	// result and spin directions
	function automatic logic spin_rule(input logic [15:0] g, input logic [15:0] cur);
		logic ch, gh, r;
		ch = cur >= CENTI_HALF;
		gh = g >= CENTI_HALF;
		if (ch && gh) r = cur > g;
		else if (!ch && !gh) r = g > cur;
		else r = !ch;
		return r;
	endfunction

	out_t res_c;

	always_comb begin
		res_c = '0;
		if (!mode_q) begin
			res_c.g1 = c1_s10;
			res_c.d1 = spin_rule(c1_s10, cur1_dly);
		end else if (oor_dly) begin
			res_c.oor = 1'b1;
		end else begin
			res_c.g1 = c1_s10;
			res_c.g2 = c2_s10;
			res_c.d1 = !spin_rule(c1_s10, cur1_dly);
			res_c.d2 = spin_rule(c2_s10, cur2_dly);
		end
	end

	// two-entry output buffer
	out_t head_q, skid_q;
	logic push, pop;

	assign push = en && vld_q[LAT-1];
	assign pop  = hv_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (pop) begin
				hv_q <= sv_q || push;
				sv_q <= sv_q && push;
			end else if (push) begin
				hv_q <= 1'b1;
				sv_q <= hv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sv_q) begin
				head_q <= skid_q;
				if (push) skid_q <= res_c;
			end else if (push) begin
				head_q <= res_c;
			end
		end else if (push) begin
			if (!hv_q) head_q <= res_c;
			else skid_q <= res_c;
		end
	end

	assign m_tvalid = hv_q;
	assign m_tdata  = {6'd0, head_q.d2, head_q.d1, head_q.g2, head_q.g1};
	assign m_tuser  = head_q.oor;

endmodule

/* bench/tb.sv */
// testbench of the two-link arm inverse kinematics block: directed and random target points
`timescale 1ns / 1ps

module tb;
	import tlik_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = 50 + STEPS;
	localparam longint LIMIT = 400000;
	localparam longint HALF_TURN = 64'sd2147483648;
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint FULL_TURN = 64'sd4294967296;

	localparam longint ARC_TAB [0:31] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
		'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
		'h00000001, 'h00000000
	};

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0] cur1;
		logic [15:0] cur2;
	} target_t;

	typedef struct {
		logic [15:0] goal1;
		logic [15:0] goal2;
		logic spin1;
		logic spin2;
		logic oor;
	} joint_goal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tuser;

	// predictor copy of the registers
	logic arm_mode = 1'b1;
	longint link1 = 1000;
	longint link2 = 1000;

	joint_goal_t goal_q[$];
	int errors = 0;
	longint cycles = 0;
	int burst_left = 0;
	int gap_max = 4;
	int rx_mode = 0;
	int hold_req = 0;
	int hold_left = 0;

	two_link_arm_inverse_kinematics DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned magn(longint v);
		return (v < 0) ? 64'd0 - longint'(v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// vectoring cordic, binary angle with a full turn of 2^32
	function automatic longint arc_bin(longint yv, longint xv);
		longint unsigned mx, my, m;
		longint x, y, z, xs, ys;
		mx = magn(xv);
		my = magn(yv);
		z = 0;
		if (mx == 0 && my == 0) return 0;
		m = (mx > my) ? mx : my;
		while (m >= (64'd1 << 41)) begin
			mx = mx >> 1; my = my >> 1; m = m >> 1;
		end
		while (m < (64'd1 << 40)) begin
			mx = mx << 1; my = my << 1; m = m << 1;
		end
		x = (xv < 0) ? -longint'(mx) : longint'(mx);
		y = (yv < 0) ? -longint'(my) : longint'(my);
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ARC_TAB[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ARC_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic logic [15:0] centideg(longint z);
		longint unsigned q;
		longint c;
		q = (magn(z) * 64'd36000) >> 32;
		c = (z < 0) ? -longint'(q) : longint'(q);
		c = c % 36000;
		if (c < 0) c = c + 36000;
		return 16'(c);
	endfunction

	function automatic logic spin_toward(logic [15:0] goal, logic [15:0] cur);
		logic ch, gh;
		ch = cur >= 16'd18000;
		gh = goal >= 16'd18000;
		if (ch && gh) return cur > goal;
		if (!ch && !gh) return goal > cur;
		return !ch;
	endfunction

	function automatic joint_goal_t solve_joints(target_t t);
		joint_goal_t r;
		longint x, y, d, s, t1, t2, phi;
		longint unsigned sq, lsum, n, ad;
		x = longint'(t.x);
		y = longint'(t.y);
		r = '{default: '0};
		if (!arm_mode) begin
			r.goal1 = centideg(arc_bin(x, y));
			r.spin1 = spin_toward(r.goal1, t.cur1);
		end else begin
			sq = magn(x) * magn(x) + magn(y) * magn(y);
			lsum = link1 * link1 + link2 * link2;
			n = 2 * link1 * link2;
			if (sq > lsum + n || sq + n < lsum) begin
				r.oor = 1'b1;
			end else begin
				d = longint'(sq) - longint'(lsum);
				ad = magn(d);
				s = longint'(int_sqrt(n * n - ad * ad));
				t2 = arc_bin(s, d);
				phi = arc_bin(link2 * s, link1 * longint'(n) + link2 * d);
				t1 = QUARTER_TURN - arc_bin(y, x) + phi;
				r.goal1 = centideg(t1);
				r.goal2 = centideg(FULL_TURN - t2);
				r.spin1 = !spin_toward(r.goal1, t.cur1);
				r.spin2 = spin_toward(r.goal2, t.cur2);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// one transaction on the input side, with bursts and gaps
	task automatic send_target(target_t t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {t.cur2, t.cur1, t.y, t.x};
		do @(posedge clk); while (!s_tready);
		goal_q.push_back(solve_joints(t));
	endtask

	task automatic send_point(int x, int y, int c1, int c2);
		target_t t;
		t.x = 16'(x);
		t.y = 16'(y);
		t.cur1 = 16'(c1);
		t.cur2 = 16'(c2);
		send_target(t);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (goal_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODE: arm_mode = value[0];
			CFG_LINK1: link1 = value & 'h7FFF;
			CFG_LINK2: link2 = value & 'h7FFF;
			default: ;
		endcase
	endtask

	function automatic int rand_angle();
		return $urandom_range(0, 35999);
	endfunction

	// mostly points inside the reach box of the arm, some anywhere
	task automatic send_random(int count);
		int span;
		for (int k = 0; k < count; k++) begin
			span = link1 + link2;
			if (span > 32767) span = 32767;
			if ($urandom_range(0, 9) < 7)
				send_point($urandom_range(0, 2 * span) - span,
					$urandom_range(0, 2 * span) - span, rand_angle(), rand_angle());
			else
				send_point(int'(16'($urandom)) - 32768, int'(16'($urandom)) - 32768,
					rand_angle(), rand_angle());
		end
	endtask

	task automatic test_directed_two_joint;
		send_point(2000, 0, 0, 0);
		send_point(0, 2000, 35999, 35999);
		send_point(-2000, 0, 18000, 17999);
		send_point(0, -2000, 17999, 18000);
		send_point(0, 0, 0, 35999);
		send_point(1000, 1000, 9000, 27000);
		send_point(-1000, -1000, 27000, 9000);
		send_point(2001, 0, 100, 100);
		send_point(32767, 32767, 0, 0);
		send_point(-32768, -32768, 0, 0);
		send_point(1, 0, 35999, 0);
	endtask

	task automatic test_single_joint;
		cfg_write(CFG_MODE, 0);
		send_point(0, 0, 0, 0);
		send_point(32767, 0, 18000, 0);
		send_point(-32768, 0, 17999, 35999);
		send_point(0, 32767, 35999, 0);
		send_point(0, -32768, 0, 0);
		send_point(-1, -1, 9000, 0);
		send_point(-1, 1, 27000, 0);
		send_point(1, -32768, 0, 0);
		rx_mode = 1;
		send_random(200);
		drain();
	endtask

	task automatic test_link_settings;
		int lens [0:4][0:1] = '{'{1, 1}, '{32767, 32767}, '{1, 32767}, '{1200, 300},
			'{$urandom_range(1, 16000), $urandom_range(1, 16000)}};
		cfg_write(CFG_MODE, 1);
		for (int c = 0; c < 5; c++) begin
			cfg_write(CFG_LINK1, lens[c][0]);
			cfg_write(CFG_LINK2, lens[c][1]);
			rx_mode = c % 3;
			gap_max = (c == 2) ? 0 : 5;
			send_point(lens[c][0] + lens[c][1], 0, 0, 0);
			send_point(lens[c][0] - lens[c][1], 0, 0, 0);
			send_random(90);
			drain();
		end
	endtask

	task automatic test_backpressure;
		cfg_write(CFG_LINK1, 700);
		cfg_write(CFG_LINK2, 900);
		gap_max = 0;
		rx_mode = 1;
		hold_req = 400;
		send_random(150);
		gap_max = 4;
		drain();
	endtask

	// receiver readiness: always ready, random stalls, or a fixed pattern; a requested hold overrides them
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= (cycles % 7) < 4;
			endcase
		end
	end

	always @(posedge clk) begin
		joint_goal_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (goal_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[15:0], -1);
			end else begin
				want = goal_q.pop_front();
				if (m_tdata[15:0] !== want.goal1)
					report_mismatch("goal_angle_1", m_tdata[15:0], want.goal1);
				if (m_tdata[31:16] !== want.goal2)
					report_mismatch("goal_angle_2", m_tdata[31:16], want.goal2);
				if (m_tdata[32] !== want.spin1)
					report_mismatch("spin_dir_1", m_tdata[32], want.spin1);
				if (m_tdata[33] !== want.spin2)
					report_mismatch("spin_dir_2", m_tdata[33], want.spin2);
				if (m_tuser !== want.oor)
					report_mismatch("out_of_reach", m_tuser, want.oor);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[two_link_arm_inverse_kinematics] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_two_joint();
		drain();
		test_single_joint();
		test_link_settings();
		test_backpressure();
		if (errors == 0 && goal_q.size() == 0) begin
			$display("[two_link_arm_inverse_kinematics] OK");
		end else begin
			$display("[two_link_arm_inverse_kinematics] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_delay.sv
hw/rtl/tlik_sqrt_cell.sv
hw/rtl/tlik_norm_cell.sv
hw/rtl/tlik_cordic_cell.sv
hw/rtl/two_link_arm_inverse_kinematics.sv
bench/tb.sv
